// ===== hdl/sorted_table_linear_interpolator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted table interpolator
// Implication checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define STLI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define STLI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STLI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define STLI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/stli_pkg.sv =====
// ---------------------------------------------------------------------------
// stli_pkg
// Shared constants, command codes and interface types of the interpolator.
// ---------------------------------------------------------------------------
package stli_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ENT_W     = KEY_W + 2 * VAL_W;
  localparam int MAG_W     = 33;
  localparam int PROD_W    = 66;
  localparam int QC_W      = 41;
  localparam int SUM_W     = 43;
  localparam int CNT_W     = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 5'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN_RD   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN_CMP  = 5'd3;
  localparam logic [CMD_W-1:0] CMD_WR_HIT    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_OUT_FULL  = 5'd5;
  localparam logic [CMD_W-1:0] CMD_OUT_EMPTY = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SHIFT_INI = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SHIFT_RD  = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SHIFT_WR  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_WR_NEW    = 5'd10;
  localparam logic [CMD_W-1:0] CMD_RD_ZERO   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_OUT_RD    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_RD_LO     = 5'd13;
  localparam logic [CMD_W-1:0] CMD_GRAB_LO   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_GRAB_HI   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_MUL_INI   = 5'd16;
  localparam logic [CMD_W-1:0] CMD_MUL_STEP  = 5'd17;
  localparam logic [CMD_W-1:0] CMD_DIV_INI   = 5'd18;
  localparam logic [CMD_W-1:0] CMD_DIV_STEP  = 5'd19;
  localparam logic [CMD_W-1:0] CMD_FINISH    = 5'd20;

  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic             part;   // 0 real, 1 imaginary
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic at_end;
    logic key_lt;
    logic hit;
    logic full;
    logic empty;
    logic one;
    logic ptr_at_pos;
    logic cnt_zero;
  } stat_t;

endpackage

// ===== hdl/stli_dp.sv =====
// ---------------------------------------------------------------------------
// stli_dp
// Datapath: entry memory, search and shift pointers, serial multiplier and
// restoring divider shared by both value parts, result registers.
// ---------------------------------------------------------------------------
`include "sorted_table_linear_interpolator_assert.svh"

module stli_dp import stli_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    opcode,
  input  logic        [KEY_W-1:0] wavelength,
  input  logic signed [VAL_W-1:0] value_re,
  input  logic signed [VAL_W-1:0] value_im,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic signed [VAL_W-1:0] result_re,
  output logic signed [VAL_W-1:0] result_im,
  output logic              [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data;

  logic                    op_q;
  logic        [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] vre_q, vim_q;
  logic [CW-1:0]           pos, count, ptr;
  logic                    hit;
  logic        [KEY_W-1:0] lo_key, hi_key;
  logic signed [VAL_W-1:0] lo_re, lo_im, hi_re, hi_im;
  logic                    anchor_lo;
  logic [PROD_W-1:0]       acc, mc;
  logic [MAG_W-1:0]        mp;
  logic [KEY_W-1:0]        rem;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;

  // memory port controls
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [ENT_W-1:0]  wdata;

  logic        [KEY_W-1:0] rd_key;
  logic signed [VAL_W-1:0] rd_re, rd_im;
  logic [CW-1:0]           lo_idx, hi_idx;

  logic signed [VAL_W-1:0] v_lo, v_hi, va;
  logic        [KEY_W-1:0] ka, run;
  logic signed [MAG_W-1:0] rise, dx;
  logic        [MAG_W-1:0] rise_mag, dx_mag;
  logic        [KEY_W:0]   rem_sh;
  logic                    rem_ge;
  logic                    q_big;
  logic        [QC_W-1:0]  qc;
  logic signed [SUM_W-1:0] delta, sum;
  logic signed [VAL_W-1:0] sat;

  assign rd_key = rd_data[ENT_W-1 -: KEY_W];
  assign rd_re  = rd_data[2*VAL_W-1 -: VAL_W];
  assign rd_im  = rd_data[VAL_W-1:0];

  always_comb begin
    if (pos == '0) begin
      lo_idx = '0;
      hi_idx = CW'(1);
    end else if (pos == count) begin
      lo_idx = count - CW'(2);
      hi_idx = count - CW'(1);
    end else begin
      lo_idx = pos - CW'(1);
      hi_idx = pos;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = {key_q, vre_q, vim_q};
    re    = 1'b0;
    raddr = pos[AW-1:0];
    case (cmd.code)
      CMD_SCAN_RD: re = 1'b1;
      CMD_WR_HIT,
      CMD_WR_NEW:  we = 1'b1;
      CMD_SHIFT_RD: begin
        re    = 1'b1;
        raddr = AW'(ptr - CW'(1));
      end
      CMD_SHIFT_WR: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = rd_data;
      end
      CMD_RD_ZERO: begin
        re    = 1'b1;
        raddr = '0;
      end
      CMD_RD_LO: begin
        re    = 1'b1;
        raddr = lo_idx[AW-1:0];
      end
      CMD_GRAB_LO: begin
        re    = 1'b1;
        raddr = hi_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // interpolation operands of the selected part
  always_comb begin
    v_lo     = cmd.part ? lo_im : lo_re;
    v_hi     = cmd.part ? hi_im : hi_re;
    va       = anchor_lo ? v_lo : v_hi;
    ka       = anchor_lo ? lo_key : hi_key;
    run      = hi_key - lo_key;
    rise     = MAG_W'(v_hi) - MAG_W'(v_lo);
    dx       = $signed({1'b0, key_q}) - $signed({1'b0, ka});
    rise_mag = rise[MAG_W-1] ? MAG_W'(-rise) : MAG_W'(rise);
    dx_mag   = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    rem_sh   = {rem, acc[PROD_W-1]};
    rem_ge   = rem_sh >= {1'b0, run};
    q_big    = (|acc[PROD_W-1:QC_W]) || (acc[QC_W-1] && (|acc[QC_W-2:0]));
    qc       = q_big ? {1'b1, {(QC_W-1){1'b0}}} : acc[QC_W-1:0];
    delta    = neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    sum      = SUM_W'(va) + delta;
    if (sum > SUM_W'(32'sh7fff_ffff)) begin
      sat = 32'sh7fff_ffff;
    end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pos    <= '0;
      ptr    <= '0;
      hit    <= 1'b0;
      status <= ST_OK;
    end else begin
      case (cmd.code)
        CMD_LOAD: begin
          op_q      <= opcode;
          key_q     <= wavelength;
          vre_q     <= value_re;
          vim_q     <= value_im;
          pos       <= '0;
          hit       <= 1'b0;
          result_re <= '0;
          result_im <= '0;
          status    <= ST_OK;
        end
        CMD_SCAN_CMP: begin
          if (rd_key < key_q) begin
            pos <= pos + CW'(1);
          end else begin
            hit <= rd_key == key_q;
          end
        end
        CMD_OUT_FULL:  status <= ST_FULL;
        CMD_OUT_EMPTY: status <= ST_EMPTY;
        CMD_SHIFT_INI: ptr <= count;
        CMD_SHIFT_WR:  ptr <= ptr - CW'(1);
        CMD_WR_NEW:    count <= count + CW'(1);
        CMD_OUT_RD: begin
          result_re <= rd_re;
          result_im <= rd_im;
        end
        CMD_GRAB_LO: begin
          lo_key    <= rd_key;
          lo_re     <= rd_re;
          lo_im     <= rd_im;
          anchor_lo <= pos == '0;
        end
        CMD_GRAB_HI: begin
          hi_key <= rd_key;
          hi_re  <= rd_re;
          hi_im  <= rd_im;
        end
        CMD_MUL_INI: begin
          acc <= '0;
          mc  <= PROD_W'(rise_mag);
          mp  <= dx_mag;
          neg <= rise[MAG_W-1] ^ dx[MAG_W-1];
          cnt <= CNT_W'(MAG_W - 1);
        end
        CMD_MUL_STEP: begin
          if (mp[0]) begin
            acc <= acc + mc;
          end
          mc  <= mc << 1;
          mp  <= mp >> 1;
          cnt <= cnt - CNT_W'(1);
        end
        CMD_DIV_INI: begin
          rem <= '0;
          cnt <= CNT_W'(PROD_W - 1);
        end
        CMD_DIV_STEP: begin
          rem <= rem_ge ? KEY_W'(rem_sh - {1'b0, run}) : rem_sh[KEY_W-1:0];
          acc <= {acc[PROD_W-2:0], rem_ge};
          cnt <= cnt - CNT_W'(1);
        end
        CMD_FINISH: begin
          if (cmd.part) begin
            result_im <= sat;
          end else begin
            result_re <= sat;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.is_query   = op_q == OP_QUERY;
  assign stat.at_end     = pos == count;
  assign stat.key_lt     = rd_key < key_q;
  assign stat.hit        = hit;
  assign stat.full       = count == CW'(DEPTH);
  assign stat.empty      = count == '0;
  assign stat.one        = count == CW'(1);
  assign stat.ptr_at_pos = ptr == pos;
  assign stat.cnt_zero   = cnt == '0;

  `STLI_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `STLI_ASSERT_NXT(a_count_grow, clk, rst, cmd.code == CMD_WR_NEW, count == $past(count) + CW'(1), "insert did not grow table")
  `STLI_ASSERT_IMP(a_shift_above, clk, rst, cmd.code == CMD_SHIFT_WR, ptr > pos, "shift went below insert point")
  `STLI_ASSERT_IMP(a_new_not_full, clk, rst, cmd.code == CMD_WR_NEW, count < CW'(DEPTH), "new entry into full table")

endmodule

// ===== hdl/stli_ctrl.sv =====
// ---------------------------------------------------------------------------
// stli_ctrl
// Controller: sequences search, insert shift and interpolation steps.
// ---------------------------------------------------------------------------
`include "sorted_table_linear_interpolator_assert.svh"

module stli_ctrl import stli_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_SHIFT    = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_GRAB_LO  = 4'd7;
  localparam logic [3:0] S_GRAB_HI  = 4'd8;
  localparam logic [3:0] S_MUL_INI  = 4'd9;
  localparam logic [3:0] S_MUL      = 4'd10;
  localparam logic [3:0] S_DIV_INI  = 4'd11;
  localparam logic [3:0] S_DIV      = 4'd12;
  localparam logic [3:0] S_FINISH   = 4'd13;

  logic [3:0] state, state_next;
  logic       part, part_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    part_next  = part;
    done_next  = 1'b0;
    cmd.code   = CMD_NONE;
    cmd.part   = part;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.code   = CMD_LOAD;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.at_end) begin
          state_next = S_DECIDE;
        end else begin
          cmd.code   = CMD_SCAN_RD;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.code   = CMD_SCAN_CMP;
        state_next = stat.key_lt ? S_SCAN_RD : S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.is_query) begin
          if (stat.hit) begin
            cmd.code   = CMD_WR_HIT;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else if (stat.full) begin
            cmd.code   = CMD_OUT_FULL;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.code   = CMD_SHIFT_INI;
            state_next = S_SHIFT;
          end
        end else if (stat.empty) begin
          cmd.code   = CMD_OUT_EMPTY;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.one) begin
          cmd.code   = CMD_RD_ZERO;
          state_next = S_OUT_RD;
        end else if (stat.hit) begin
          // read data still holds the matching entry
          cmd.code   = CMD_OUT_RD;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.code   = CMD_RD_LO;
          state_next = S_GRAB_LO;
        end
      end
      S_SHIFT: begin
        if (stat.ptr_at_pos) begin
          cmd.code   = CMD_WR_NEW;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.code   = CMD_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.code   = CMD_SHIFT_WR;
        state_next = S_SHIFT;
      end
      S_OUT_RD: begin
        cmd.code   = CMD_OUT_RD;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_GRAB_LO: begin
        cmd.code   = CMD_GRAB_LO;
        state_next = S_GRAB_HI;
      end
      S_GRAB_HI: begin
        cmd.code   = CMD_GRAB_HI;
        part_next  = 1'b0;
        state_next = S_MUL_INI;
      end
      S_MUL_INI: begin
        cmd.code   = CMD_MUL_INI;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.code = CMD_MUL_STEP;
        if (stat.cnt_zero) begin
          state_next = S_DIV_INI;
        end
      end
      S_DIV_INI: begin
        cmd.code   = CMD_DIV_INI;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.code = CMD_DIV_STEP;
        if (stat.cnt_zero) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.code = CMD_FINISH;
        if (part) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          part_next  = 1'b1;
          state_next = S_MUL_INI;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      part  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      part  <= part_next;
      done  <= done_next;
    end
  end

  assign busy = state != S_IDLE;

  `STLI_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `STLI_ASSERT_NXT(a_start_scan, clk, rst, start && !busy, state == S_SCAN_RD, "accepted item did not start search")

endmodule

// ===== hdl/sorted_table_linear_interpolator.sv =====
// ---------------------------------------------------------------------------
// sorted_table_linear_interpolator
// Sorted complex table with insert/overwrite and linear interpolation query.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy low; exactly one result per
// item appears on result_re, result_im and status for one cycle with done
// high, and cannot be held off. Items run one at a time. The key search
// over the entry memory reads and compares one entry at a time; an insert
// that opens a slot moves each following entry up by one, reading and then
// writing it; an interpolating query runs the shift-add multiplier and
// restoring divider once per value part. Other items finish after the
// search with no multiply or divide.

module sorted_table_linear_interpolator import stli_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode,
  input  logic        [KEY_W-1:0] wavelength,
  input  logic signed [VAL_W-1:0] value_re,
  input  logic signed [VAL_W-1:0] value_im,
  output logic                    done,
  output logic signed [VAL_W-1:0] result_re,
  output logic signed [VAL_W-1:0] result_im,
  output logic              [1:0] status
);

  cmd_t  cmd;
  stat_t stat;

  stli_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  stli_dp #(
    .DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .wavelength(wavelength),
    .value_re  (value_re),
    .value_im  (value_im),
    .cmd       (cmd),
    .stat      (stat),
    .result_re (result_re),
    .result_im (result_im),
    .status    (status)
  );

endmodule

// ===== verif/stli_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stli_checker
// Watches accepted items and results of the table interpolator, predicts
// every result from a private copy of the sorted table, and compares.
// ---------------------------------------------------------------------------
module stli_checker import stli_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    opcode,
  input  logic        [KEY_W-1:0] wavelength,
  input  logic signed [VAL_W-1:0] value_re,
  input  logic signed [VAL_W-1:0] value_im,
  input  logic                    done,
  input  logic signed [VAL_W-1:0] result_re,
  input  logic signed [VAL_W-1:0] result_im,
  input  logic              [1:0] status,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic [1:0]              st;
  } answer_t;

  logic [KEY_W-1:0]        tbl_key [TABLE_DEPTH];
  logic signed [VAL_W-1:0] tbl_re  [TABLE_DEPTH];
  logic signed [VAL_W-1:0] tbl_im  [TABLE_DEPTH];
  int                      tbl_len;
  answer_t                 answers [$];

  // Exact product and quotient in wide vectors, magnitude clamped to 2^40.
  function automatic logic signed [VAL_W-1:0] blend(
    logic signed [VAL_W-1:0] v_lo, logic signed [VAL_W-1:0] v_hi,
    logic signed [VAL_W-1:0] v_anchor, logic [KEY_W-1:0] k_lo,
    logic [KEY_W-1:0] k_hi, logic [KEY_W-1:0] k_anchor, logic [KEY_W-1:0] q);
    logic signed [127:0] rise, dx, prod, quo, sum;
    rise = 128'(signed'(v_hi)) - 128'(signed'(v_lo));
    dx   = $signed({96'd0, q}) - $signed({96'd0, k_anchor});
    if (k_hi == k_lo) return v_anchor;
    prod = rise * dx;
    quo  = prod / $signed({96'd0, k_hi - k_lo});
    if (quo > (128'sd1 <<< 40)) quo = 128'sd1 <<< 40;
    if (quo < -(128'sd1 <<< 40)) quo = -(128'sd1 <<< 40);
    sum = 128'(signed'(v_anchor)) + quo;
    if (sum > 128'sd2147483647) return 32'sh7fffffff;
    if (sum < -128'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  task automatic apply_item(logic op, logic [KEY_W-1:0] key,
                            logic signed [VAL_W-1:0] vre, logic signed [VAL_W-1:0] vim);
    int pos, lo, hi, an;
    answer_t a;
    pos = 0;
    a = '{re: '0, im: '0, st: ST_OK};
    while (pos < tbl_len && tbl_key[pos] < key) pos++;
    if (op == OP_INSERT) begin
      if (pos < tbl_len && tbl_key[pos] == key) begin
        tbl_re[pos] = vre;
        tbl_im[pos] = vim;
      end else if (tbl_len >= TABLE_DEPTH) begin
        a.st = ST_FULL;
      end else begin
        for (int i = tbl_len; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_re[i]  = tbl_re[i-1];
          tbl_im[i]  = tbl_im[i-1];
        end
        tbl_key[pos] = key;
        tbl_re[pos]  = vre;
        tbl_im[pos]  = vim;
        tbl_len++;
      end
    end else if (tbl_len == 0) begin
      a.st = ST_EMPTY;
    end else if (tbl_len == 1) begin
      a.re = tbl_re[0];
      a.im = tbl_im[0];
    end else if (pos < tbl_len && tbl_key[pos] == key) begin
      a.re = tbl_re[pos];
      a.im = tbl_im[pos];
    end else begin
      if (pos == 0) begin
        lo = 0; hi = 1; an = 0;
      end else if (pos == tbl_len) begin
        lo = tbl_len - 2; hi = tbl_len - 1; an = tbl_len - 1;
      end else begin
        lo = pos - 1; hi = pos; an = pos;
      end
      a.re = blend(tbl_re[lo], tbl_re[hi], tbl_re[an], tbl_key[lo], tbl_key[hi],
                   tbl_key[an], key);
      a.im = blend(tbl_im[lo], tbl_im[hi], tbl_im[an], tbl_key[lo], tbl_key[hi],
                   tbl_key[an], key);
    end
    answers.push_back(a);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      tbl_len = 0;
      answers.delete();
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, status}, '0);
        end else begin
          w = answers.pop_front();
          if (result_re !== w.re) report_mismatch("result_re", result_re, w.re);
          if (result_im !== w.im) report_mismatch("result_im", result_im, w.im);
          if (status !== w.st) report_mismatch("status", {30'd0, status}, {30'd0, w.st});
        end
      end
      if (start && !busy) apply_item(opcode, wavelength, value_re, value_im);
    end
    pending = answers.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random insert/query items into the table interpolator
// with random gaps; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import stli_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    opcode = OP_INSERT;
  logic        [KEY_W-1:0] wavelength = '0;
  logic signed [VAL_W-1:0] value_re = '0;
  logic signed [VAL_W-1:0] value_im = '0;
  logic                    done;
  logic signed [VAL_W-1:0] result_re, result_im;
  logic              [1:0] status;
  int                      fail_count, pending;
  int                      cycles = 0;
  logic [KEY_W-1:0]        used_keys [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_table_linear_interpolator uut (.*);
  stli_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sorted_table_linear_interpolator");
      $finish;
    end
  end

  // Present one item and hold it until taken; start drops in the gap before
  // the next item or when draining.
  task automatic send_item(logic op, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] vre, logic [VAL_W-1:0] vim);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    wavelength <= key;
    value_re <= vre;
    value_im <= vim;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT) used_keys.push_back(key);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && used_keys.size() != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 6) return $urandom_range(0, 4095) << $urandom_range(0, 20);
    if (r == 6) return $urandom_range(0, 1) ? 32'hffffffff - $urandom_range(0, 3)
                                            : $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, single entry, exact hits, extremes, steep slopes.
    send_item(OP_QUERY, 32'h0001_0000, '0, '0);
    send_item(OP_INSERT, 32'h0010_0000, 32'h7fffffff, 32'h80000000);
    send_item(OP_QUERY, 32'hffffffff, '0, '0);
    send_item(OP_QUERY, 32'h0000_0000, '0, '0);
    send_item(OP_INSERT, 32'h0010_0001, 32'h80000000, 32'h7fffffff);
    send_item(OP_QUERY, 32'h0000_0000, '0, '0);
    send_item(OP_QUERY, 32'hffffffff, '0, '0);
    send_item(OP_QUERY, 32'h0010_0001, '0, '0);
    send_item(OP_INSERT, 32'hffffffff, 32'h0100_0000, 32'hff00_0000);
    send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_item(OP_QUERY, 32'h8000_0000, '0, '0);
    send_item(OP_INSERT, 32'h0010_0000, 32'h1234_5678, 32'hedcb_a987);
    send_item(OP_QUERY, 32'h0008_0000, '0, '0);
    send_item(OP_QUERY, 32'h0010_0000, '0, '0);
    drain_results();

    // Fill the table, then hit it full with new keys and overwrites.
    for (int i = 0; i < 70; i++) send_item(OP_INSERT, $urandom, pick_val(), pick_val());
    send_item(OP_INSERT, used_keys[0], 32'h7fffffff, 32'h80000000);
    for (int i = 0; i < 150; i++)
      send_item(1'($urandom_range(0, 1)), pick_key(), pick_val(), pick_val());
    drain_results();

    // Random, mostly queries against the full table.
    for (int i = 0; i < 1300; i++)
      send_item($urandom_range(0, 3) != 0, pick_key(), pick_val(), pick_val());

    drain_results();
    if (fail_count == 0) begin
      $display("PASS sorted_table_linear_interpolator");
    end else begin
      $display("FAIL sorted_table_linear_interpolator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/stli_pkg.sv
hdl/stli_dp.sv
hdl/stli_ctrl.sv
hdl/sorted_table_linear_interpolator.sv
verif/stli_checker.sv
verif/tb_top.sv
